// ===== rtl/core/mtg_pkg.sv =====
// Shared constants, command types and word functions for the MT19937 generator.
package mtg_pkg;

	localparam int WORDS_N    = 624;
	localparam int FAR_OFS_N  = 397;
	localparam int ADDR_W     = $clog2(WORDS_N);

	localparam logic [ADDR_W-1:0] WORDS       = ADDR_W'(WORDS_N);
	localparam logic [ADDR_W-1:0] LAST_WORD   = ADDR_W'(WORDS_N - 1);
	localparam logic [ADDR_W-1:0] UNSEEDED    = ADDR_W'(WORDS_N + 1);
	localparam logic [ADDR_W-1:0] FAR_OFS     = ADDR_W'(FAR_OFS_N);
	localparam logic [ADDR_W-1:0] FAR_WRAP    = ADDR_W'(WORDS_N - FAR_OFS_N);

	localparam logic [31:0] TWIST_XOR    = 32'h9908_b0df;
	localparam logic [31:0] HIGH_BIT     = 32'h8000_0000;
	localparam logic [31:0] LOW_BITS     = 32'h7fff_ffff;
	localparam logic [31:0] SEED_MULT    = 32'd1812433253;
	localparam logic [31:0] DEFAULT_SEED = 32'd5489;
	localparam logic [31:0] TEMPER_B     = 32'h9d2c_5680;
	localparam logic [31:0] TEMPER_C     = 32'hefc6_0000;

	// action field codes
	localparam logic ACT_DRAW = 1'b0;
	localparam logic ACT_SEED = 1'b1;

	localparam int CMD_DEPTH = 2;
	localparam int OUT_DEPTH = 2;

	typedef enum logic {
		CMD_DRAW = 1'b0,
		CMD_SEED = 1'b1
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t   kind;
		logic [31:0] seed;
	} cmd_t;

	typedef struct packed {
		logic        push;
		logic [31:0] word;
	} out_push_t;

	// one step of the seeding recurrence
	function automatic logic [31:0] seed_step(input logic [31:0] prev,
		input logic [ADDR_W-1:0] i);
		logic [31:0] x;
		logic [31:0] p;
		x = prev ^ (prev >> 30);
		p = x * SEED_MULT;
		return p + 32'(i);
	endfunction

	// one word of the regeneration pass
	function automatic logic [31:0] twist_word(input logic [31:0] cur,
		input logic [31:0] nxt, input logic [31:0] far);
		logic [31:0] y;
		logic [31:0] v;
		y = (cur & HIGH_BIT) | (nxt & LOW_BITS);
		v = far ^ (y >> 1);
		if (y[0]) begin
			v = v ^ TWIST_XOR;
		end
		return v;
	endfunction

	function automatic logic [31:0] temper(input logic [31:0] w);
		logic [31:0] t;
		t = w ^ (w >> 11);
		t = t ^ ((t << 7) & TEMPER_B);
		t = t ^ ((t << 15) & TEMPER_C);
		t = t ^ (t >> 18);
		return t;
	endfunction

endpackage

// ===== rtl/core/mtg_front.sv =====
// Front end: takes input words, classifies them and queues commands.
module mtg_front #(
	parameter int CmdDepth = mtg_pkg::CMD_DEPTH
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic          action,
	input  logic [31:0]   seed,
	output logic          cmd_valid,
	output mtg_pkg::cmd_t cmd,
	input  logic          cmd_pop
);
	import mtg_pkg::*;

	localparam int PW = (CmdDepth > 1) ? $clog2(CmdDepth) : 1;
	localparam int CW = $clog2(CmdDepth + 1);

	cmd_t          slot_q [CmdDepth];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] cnt_q;
	logic          push;
	cmd_t          item;

	assign in_ready  = (cnt_q < CW'(CmdDepth));
	assign push      = in_valid && in_ready;
	assign cmd_valid = (cnt_q != '0);
	assign cmd       = slot_q[rd_ptr_q];

	always_comb begin
		item.kind = (action == ACT_SEED) ? CMD_SEED : CMD_DRAW;
		item.seed = seed;
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(CmdDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (cmd_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(CmdDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			cnt_q <= cnt_q + CW'(push) - CW'(cmd_pop);
		end
	end

endmodule

// ===== rtl/core/mtg_back.sv =====
// Back end: state memory, seeding and regeneration sequencer, draw read path.
module mtg_back #(
	parameter int OutDepth = mtg_pkg::OUT_DEPTH,
	localparam int CW = $clog2(OutDepth + 1)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	input  mtg_pkg::cmd_t      cmd,
	output logic               cmd_pop,
	input  logic [CW-1:0]      out_cnt,
	input  logic               out_pop,
	output mtg_pkg::out_push_t out_push
);
	import mtg_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_FILL  = 4'b0010,
		ST_PRIME = 4'b0100,
		ST_TWIST = 4'b1000
	} state_t;

	state_t            state_q, state_d;
	logic [ADDR_W-1:0] idx_q;
	logic [ADDR_W-1:0] cnt_q;
	logic              cmp_q;
	logic              then_twist_q;
	logic              dr_vld_s1;
	logic [31:0]       prev_q;
	logic [31:0]       cur_q;

	logic [31:0]       mem [WORDS_N];
	logic [31:0]       rd_a_q;
	logic [31:0]       rd_b_q;

	logic              we;
	logic [ADDR_W-1:0] wa;
	logic [31:0]       wd;
	logic [ADDR_W-1:0] ra;
	logic [ADDR_W-1:0] rb;
	logic              issue;
	logic              slot_ok;
	logic [ADDR_W-1:0] tw_ra;
	logic [ADDR_W-1:0] tw_rb;
	logic [31:0]       fill_word;
	logic [31:0]       tw_word;

	// a draw read may go out only if the output buffer has room once it lands
	assign slot_ok = ({1'b0, out_cnt} + (CW+1)'(dr_vld_s1))
		< ((CW+1)'(OutDepth) + (CW+1)'(out_pop));

	assign fill_word = seed_step(prev_q, cnt_q);
	assign tw_word   = twist_word(cur_q, rd_a_q, rd_b_q);
	assign tw_ra     = (cnt_q >= LAST_WORD) ? '0 : cnt_q + 1'b1;
	assign tw_rb     = (cnt_q >= FAR_WRAP) ? cnt_q - FAR_WRAP : cnt_q + FAR_OFS;

	always_comb begin
		state_d = state_q;
		we      = 1'b0;
		wa      = '0;
		wd      = fill_word;
		ra      = '0;
		rb      = '0;
		cmd_pop = 1'b0;
		issue   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd_valid) begin
					if (cmd.kind == CMD_SEED) begin
						cmd_pop = 1'b1;
						we      = 1'b1;
						wd      = cmd.seed;
						state_d = ST_FILL;
					end else if (idx_q < WORDS) begin
						if (slot_ok) begin
							cmd_pop = 1'b1;
							issue   = 1'b1;
							ra      = idx_q;
						end
					end else if (idx_q == UNSEEDED) begin
						we      = 1'b1;
						wd      = DEFAULT_SEED;
						state_d = ST_FILL;
					end else begin
						state_d = ST_PRIME;
					end
				end
			end
			ST_FILL: begin
				we = 1'b1;
				wa = cnt_q;
				if (cnt_q == LAST_WORD) begin
					state_d = then_twist_q ? ST_PRIME : ST_IDLE;
				end
			end
			ST_PRIME: begin
				state_d = ST_TWIST;
			end
			ST_TWIST: begin
				ra = tw_ra;
				rb = tw_rb;
				we = cmp_q;
				wa = cnt_q - 1'b1;
				wd = tw_word;
				if (cnt_q == WORDS) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// state memory: one write, two registered reads
	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		rd_a_q <= mem[ra];
		rd_b_q <= mem[rb];
	end

	always_ff @(posedge clk) begin
		if (we && state_q != ST_TWIST) begin
			prev_q <= wd;
		end
		if (state_q == ST_TWIST) begin
			cur_q <= rd_a_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			idx_q        <= UNSEEDED;
			cnt_q        <= '0;
			cmp_q        <= 1'b0;
			then_twist_q <= 1'b0;
			dr_vld_s1    <= 1'b0;
		end else begin
			state_q   <= state_d;
			dr_vld_s1 <= issue;
			if (issue) begin
				idx_q <= idx_q + 1'b1;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (state_d == ST_FILL) begin
						cnt_q        <= ADDR_W'(1);
						idx_q        <= WORDS;
						then_twist_q <= (cmd.kind == CMD_DRAW);
					end
				end
				ST_FILL: begin
					cnt_q <= cnt_q + 1'b1;
				end
				ST_PRIME: begin
					cnt_q <= '0;
					cmp_q <= 1'b0;
				end
				ST_TWIST: begin
					cnt_q <= cnt_q + 1'b1;
					cmp_q <= 1'b1;
					if (cnt_q == WORDS) begin
						idx_q <= '0;
					end
				end
				default: begin
					cnt_q <= '0;
				end
			endcase
		end
	end

	always_comb begin
		out_push.push = dr_vld_s1;
		out_push.word = temper(rd_a_q);
	end

endmodule

// ===== rtl/core/mtg_out.sv =====
// Output buffer: small queue of tempered words facing the consumer.
module mtg_out #(
	parameter int OutDepth = mtg_pkg::OUT_DEPTH,
	localparam int CW = $clog2(OutDepth + 1)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  mtg_pkg::out_push_t out_push,
	output logic [CW-1:0]      out_cnt,
	output logic               out_pop,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [31:0]        random_word
);
	import mtg_pkg::*;

	localparam int PW = (OutDepth > 1) ? $clog2(OutDepth) : 1;

	logic [31:0]   slot_q [OutDepth];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] cnt_q;

	assign out_valid   = (cnt_q != '0);
	assign out_pop     = out_valid && out_ready;
	assign out_cnt     = cnt_q;
	assign random_word = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (out_push.push) begin
			slot_q[wr_ptr_q] <= out_push.word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (out_push.push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(OutDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (out_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(OutDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			cnt_q <= cnt_q + CW'(out_push.push) - CW'(out_pop);
		end
	end

endmodule

// ===== rtl/core/mt19937_generator.sv =====
// Top level of the MT19937 random word generator.
//
// MT19937 generator with a 624-word state held in a single-port-write,
// dual-read memory. Each input word is either a draw (action 0), which
// returns one tempered 32-bit word, or a reseed (action 1), which refills
// the state from the seed field and returns nothing. Input words land in a
// short command queue; the back end works through them one at a time and
// hands results to a small output queue, so either side can stall alone.
// While words remain, draws go out at one per clock as long as the output
// queue has room; an accepted draw passes through the command queue, a
// registered memory read and the output queue. In a reseed the seeding
// recurrence is a serial chain through one 32x32 multiplier, one state word
// per clock. When all 624 words are used, the next draw first regenerates
// the state: one priming read, then one word per clock using both memory
// read ports. The first draw after reset seeds with 5489 and then
// regenerates before it is served. A reseed discards any unused words. No
// clearing pass is needed after reset.
module mt19937_generator #(
	parameter int CmdDepth = mtg_pkg::CMD_DEPTH,
	parameter int OutDepth = mtg_pkg::OUT_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        action,
	input  logic [31:0] seed,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] random_word
);
	import mtg_pkg::*;

	localparam int CW = $clog2(OutDepth + 1);

	logic          cmd_valid;
	cmd_t          cmd;
	logic          cmd_pop;
	logic [CW-1:0] out_cnt;
	logic          out_pop;
	out_push_t     out_push;

	// front end: accept and classify
	mtg_front #(
		.CmdDepth(CmdDepth)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.action   (action),
		.seed     (seed),
		.cmd_valid(cmd_valid),
		.cmd      (cmd),
		.cmd_pop  (cmd_pop)
	);

	// back end: state memory, seeding, regeneration, draw reads
	mtg_back #(
		.OutDepth(OutDepth)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(cmd_valid),
		.cmd      (cmd),
		.cmd_pop  (cmd_pop),
		.out_cnt  (out_cnt),
		.out_pop  (out_pop),
		.out_push (out_push)
	);

	// output queue; its fill level gates draw reads in the back end
	mtg_out #(
		.OutDepth(OutDepth)
	) u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.out_push   (out_push),
		.out_cnt    (out_cnt),
		.out_pop    (out_pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.random_word(random_word)
	);

	// a word pushed into the output queue must always find room
	assert property (@(posedge clk) disable iff (!arst_n)
		out_push.push |-> (out_cnt < CW'(OutDepth)) || out_pop)
		else $error("output queue overflow");

	// the back end only consumes a queued command
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |-> cmd_valid)
		else $error("command popped from empty queue");

	// a result always follows from a draw read in the cycle before
	assert property (@(posedge clk) disable iff (!arst_n)
		out_push.push |-> $past(cmd_pop) && $past(cmd.kind == CMD_DRAW))
		else $error("result without a draw");

endmodule
